[rtl/pfc_pkg.sv]
`timescale 1ns / 1ps

package pfc_pkg;

  // Palette geometry
  localparam int PALETTE_ENTRIES = 256;
  localparam int ADDR_W          = $clog2(PALETTE_ENTRIES);
  localparam int IDX_W           = 8;
  localparam int COMP_W          = 8;
  localparam int RGB_W           = 3 * COMP_W;
  localparam int COMP_MAX        = 255;

  // Fade arithmetic
  localparam int INC_W      = COMP_W + 1;
  localparam int OFFSET_W   = INC_W + 1;
  localparam int FADE_START = 255;

  // Stream widths
  localparam int OP_W        = 3;
  localparam int MODE_W      = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_TUSER_W = 1;

  localparam logic [RGB_W-1:0] RGB_WHITE = {RGB_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 3'd0,
    OP_CLEAR    = 3'd1,
    OP_FADE_IN  = 3'd2,
    OP_FADE_OUT = 3'd3,
    OP_TICK     = 3'd4,
    OP_READ     = 3'd5
  } opcode_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE = 2'd0,
    MODE_IN   = 2'd1,
    MODE_OUT  = 2'd2
  } fade_mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_TICK,
    ST_PUSH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;
    logic init_step;
    logic clear_step;
    logic tick_step;
    logic push;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic cnt_zero;
    logic tick_sweep;
  } dp_sts_t;

endpackage

[rtl/pfc_datapath.sv]
`timescale 1ns / 1ps

module pfc_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pfc_pkg::dp_cmd_t                  cmd,
  input  logic [pfc_pkg::OP_W-1:0]          op_in,
  input  logic [pfc_pkg::IN_TDATA_W-1:0]    item_in,
  output pfc_pkg::dp_sts_t                  sts,
  output logic [pfc_pkg::OUT_TUSER_W-1:0]   out_user,
  output logic [pfc_pkg::OUT_TDATA_W-1:0]   out_data
);

  localparam int PAD_W = pfc_pkg::OUT_TDATA_W - pfc_pkg::RGB_W - pfc_pkg::MODE_W;
  localparam logic [pfc_pkg::ADDR_W-1:0] CNT_LAST =
    pfc_pkg::ADDR_W'(pfc_pkg::PALETTE_ENTRIES - 1);
  localparam logic [pfc_pkg::ADDR_W-1:0] WHITE_ENTRY = pfc_pkg::ADDR_W'(1);
  localparam logic [pfc_pkg::IDX_W:0] IDX_LIMIT =
    (pfc_pkg::IDX_W + 1)'(pfc_pkg::PALETTE_ENTRIES);
  localparam logic signed [pfc_pkg::OFFSET_W-1:0] OFF_IN_START =
    pfc_pkg::OFFSET_W'(-pfc_pkg::FADE_START);
  localparam logic signed [pfc_pkg::OFFSET_W-1:0] OFF_OUT_START =
    pfc_pkg::OFFSET_W'(pfc_pkg::FADE_START);

  // Add the offset to one component and saturate to the component range
  function automatic logic [pfc_pkg::COMP_W-1:0] clamp_add(
    input logic        [pfc_pkg::COMP_W-1:0]   comp,
    input logic signed [pfc_pkg::OFFSET_W-1:0] offs
  );
    logic signed [pfc_pkg::OFFSET_W-1:0] s;
    s = $signed({{(pfc_pkg::OFFSET_W - pfc_pkg::COMP_W){1'b0}}, comp}) + offs;
    if (s < 0) begin
      clamp_add = '0;
    end else if (s > $signed(pfc_pkg::OFFSET_W'(pfc_pkg::COMP_MAX))) begin
      clamp_add = {pfc_pkg::COMP_W{1'b1}};
    end else begin
      clamp_add = s[pfc_pkg::COMP_W-1:0];
    end
  endfunction

  // Item fields
  pfc_pkg::opcode_t              op;
  logic [pfc_pkg::IDX_W-1:0]     idx;
  logic [pfc_pkg::RGB_W-1:0]     rgb_in;
  logic [pfc_pkg::COMP_W-1:0]    steps;
  logic [pfc_pkg::ADDR_W-1:0]    idx_a;
  logic                          idx_ok;

  assign op     = pfc_pkg::opcode_t'(op_in);
  assign idx    = item_in[pfc_pkg::IDX_W-1:0];
  assign rgb_in = item_in[pfc_pkg::IDX_W +: pfc_pkg::RGB_W];
  assign steps  = item_in[pfc_pkg::IDX_W + pfc_pkg::RGB_W +: pfc_pkg::COMP_W];
  assign idx_a  = idx[pfc_pkg::ADDR_W-1:0];
  assign idx_ok = {1'b0, idx} < IDX_LIMIT;

  // Palette stores, entries packed blue:green:red
  logic [pfc_pkg::RGB_W-1:0] base_mem  [pfc_pkg::PALETTE_ENTRIES];
  logic [pfc_pkg::RGB_W-1:0] shown_mem [pfc_pkg::PALETTE_ENTRIES];

  // Fade and item state
  pfc_pkg::fade_mode_t                 mode_r, mode_nxt;
  logic signed [pfc_pkg::INC_W-1:0]    inc_r, inc_nxt;
  logic signed [pfc_pkg::OFFSET_W-1:0] off_r, off_nxt;
  logic signed [pfc_pkg::OFFSET_W-1:0] used_r, used_nxt;
  logic                                dirty_r, dirty_nxt;
  logic                                fade_en_r, fade_en_nxt;
  logic                                loaded_r, loaded_nxt;
  logic                                rd_ok_r, rd_ok_nxt;

  // Sweep pipeline
  logic [pfc_pkg::ADDR_W-1:0] cnt_r;
  logic [pfc_pkg::RGB_W-1:0]  base_rd_r;
  logic [pfc_pkg::RGB_W-1:0]  shown_rd_r;
  logic                       wr_v_r;
  logic [pfc_pkg::ADDR_W-1:0] wr_addr_r;

  logic [pfc_pkg::OUT_TUSER_W-1:0] out_user_r;
  logic [pfc_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic signed [pfc_pkg::OFFSET_W-1:0] off_sum;
  logic                                going;
  logic [pfc_pkg::COMP_W-1:0]          steps_c;
  logic [pfc_pkg::INC_W-1:0]           inc_pos;
  logic                                step_any;

  assign off_sum  = off_r + {inc_r[pfc_pkg::INC_W-1], inc_r};
  assign going    = (mode_r == pfc_pkg::MODE_OUT) ? (off_sum > 0) : (off_sum < 0);
  assign steps_c  = (steps == '0) ? pfc_pkg::COMP_W'(1) : steps;
  assign inc_pos  = {1'b0, steps_c};
  assign step_any = cmd.init_step | cmd.clear_step | cmd.tick_step;

  // Apply an accepted item to the fade state
  always_comb begin
    mode_nxt    = mode_r;
    inc_nxt     = inc_r;
    off_nxt     = off_r;
    used_nxt    = used_r;
    dirty_nxt   = dirty_r;
    fade_en_nxt = fade_en_r;
    loaded_nxt  = loaded_r;
    rd_ok_nxt   = rd_ok_r;
    if (cmd.exec) begin
      loaded_nxt = 1'b0;
      rd_ok_nxt  = 1'b0;
      unique case (op)
        pfc_pkg::OP_WRITE: begin
          if (idx_ok) begin
            dirty_nxt = 1'b1;
          end
        end
        pfc_pkg::OP_CLEAR: begin
          dirty_nxt = 1'b1;
        end
        pfc_pkg::OP_FADE_IN: begin
          if (mode_r == pfc_pkg::MODE_IDLE) begin
            inc_nxt  = inc_pos;
            off_nxt  = OFF_IN_START;
            mode_nxt = pfc_pkg::MODE_IN;
          end
        end
        pfc_pkg::OP_FADE_OUT: begin
          if (mode_r == pfc_pkg::MODE_IDLE) begin
            inc_nxt  = '0 - inc_pos;
            off_nxt  = OFF_OUT_START;
            mode_nxt = pfc_pkg::MODE_OUT;
          end
        end
        pfc_pkg::OP_TICK: begin
          if (mode_r == pfc_pkg::MODE_IDLE) begin
            if (dirty_r) begin
              dirty_nxt   = 1'b0;
              fade_en_nxt = 1'b0;
              loaded_nxt  = 1'b1;
            end
          end else begin
            dirty_nxt   = 1'b0;
            used_nxt    = off_r;
            off_nxt     = off_sum;
            fade_en_nxt = going;
            loaded_nxt  = 1'b1;
            if (!going) begin
              mode_nxt = pfc_pkg::MODE_IDLE;
            end
          end
        end
        pfc_pkg::OP_READ: begin
          rd_ok_nxt = idx_ok;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pfc_pkg::MODE_IDLE;
      inc_r     <= '0;
      off_r     <= '0;
      dirty_r   <= 1'b0;
      fade_en_r <= 1'b0;
      loaded_r  <= 1'b0;
      rd_ok_r   <= 1'b0;
      used_r    <= '0;
    end else begin
      mode_r    <= mode_nxt;
      inc_r     <= inc_nxt;
      off_r     <= off_nxt;
      dirty_r   <= dirty_nxt;
      fade_en_r <= fade_en_nxt;
      loaded_r  <= loaded_nxt;
      rd_ok_r   <= rd_ok_nxt;
      used_r    <= used_nxt;
    end
  end

  // Advance the sweep counter, wrap after the last entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      wr_v_r <= 1'b0;
    end else begin
      if (step_any) begin
        cnt_r <= (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
      end
      wr_v_r <= cmd.tick_step;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= cnt_r;
  end

  // Base store: one write port, one registered read port for the sweep
  logic                       base_we;
  logic [pfc_pkg::ADDR_W-1:0] base_wa;
  logic [pfc_pkg::RGB_W-1:0]  base_wd;

  always_comb begin
    base_we = 1'b0;
    base_wa = idx_a;
    base_wd = rgb_in;
    if (cmd.init_step) begin
      base_we = 1'b1;
      base_wa = cnt_r;
      base_wd = '0;
    end else if (cmd.clear_step) begin
      base_we = 1'b1;
      base_wa = cnt_r;
      base_wd = (cnt_r == WHITE_ENTRY) ? pfc_pkg::RGB_WHITE : '0;
    end else if (cmd.exec && op == pfc_pkg::OP_WRITE && idx_ok) begin
      base_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (base_we) begin
      base_mem[base_wa] <= base_wd;
    end
    if (cmd.tick_step) begin
      base_rd_r <= base_mem[cnt_r];
    end
  end

  // Shown store: sweep or reset clearing writes, item reads
  logic [pfc_pkg::RGB_W-1:0]  sweep_wd;
  logic                       shown_we;
  logic [pfc_pkg::ADDR_W-1:0] shown_wa;
  logic [pfc_pkg::RGB_W-1:0]  shown_wd;

  always_comb begin
    sweep_wd = base_rd_r;
    if (fade_en_r) begin
      for (int c = 0; c < 3; c++) begin
        sweep_wd[c*pfc_pkg::COMP_W +: pfc_pkg::COMP_W] =
          clamp_add(base_rd_r[c*pfc_pkg::COMP_W +: pfc_pkg::COMP_W], used_r);
      end
    end
  end

  assign shown_we = cmd.init_step | wr_v_r;
  assign shown_wa = cmd.init_step ? cnt_r : wr_addr_r;
  assign shown_wd = cmd.init_step ? '0 : sweep_wd;

  always_ff @(posedge clk) begin
    if (shown_we) begin
      shown_mem[shown_wa] <= shown_wd;
    end
    if (cmd.exec && op == pfc_pkg::OP_READ) begin
      shown_rd_r <= shown_mem[idx_a];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_user_r <= loaded_r;
      out_data_r <= {{PAD_W{1'b0}}, (rd_ok_r ? shown_rd_r : '0), mode_r};
    end
  end

  assign out_user = out_user_r;
  assign out_data = out_data_r;

  assign sts.cnt_last   = cnt_r == CNT_LAST;
  assign sts.cnt_zero   = cnt_r == '0;
  assign sts.tick_sweep = (mode_r != pfc_pkg::MODE_IDLE) || dirty_r;

endmodule

[rtl/pfc_ctrl.sv]
`timescale 1ns / 1ps

module pfc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic [pfc_pkg::OP_W-1:0]  in_op,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  input  pfc_pkg::dp_sts_t          sts,
  output pfc_pkg::dp_cmd_t          cmd
);

  pfc_pkg::ctrl_state_t state_r, state_nxt;
  pfc_pkg::opcode_t     op;
  logic                 out_valid_r;
  logic                 in_acc;
  logic                 push;

  assign op     = pfc_pkg::opcode_t'(in_op);
  assign in_acc = in_tvalid && (state_r == pfc_pkg::ST_IDLE);
  assign push   = (state_r == pfc_pkg::ST_PUSH) && (!out_valid_r || out_tready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfc_pkg::ST_INIT: begin
        if (sts.cnt_last) begin
          state_nxt = pfc_pkg::ST_IDLE;
        end
      end
      pfc_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (op == pfc_pkg::OP_CLEAR) begin
            state_nxt = pfc_pkg::ST_CLEAR;
          end else if (op == pfc_pkg::OP_TICK && sts.tick_sweep) begin
            state_nxt = pfc_pkg::ST_TICK;
          end else begin
            state_nxt = pfc_pkg::ST_PUSH;
          end
        end
      end
      pfc_pkg::ST_CLEAR, pfc_pkg::ST_TICK: begin
        if (sts.cnt_last) begin
          state_nxt = pfc_pkg::ST_PUSH;
        end
      end
      pfc_pkg::ST_PUSH: begin
        if (push) begin
          state_nxt = pfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pfc_pkg::ST_INIT;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_tready      = state_r == pfc_pkg::ST_IDLE;
    cmd.exec       = in_acc;
    cmd.init_step  = state_r == pfc_pkg::ST_INIT;
    cmd.clear_step = state_r == pfc_pkg::ST_CLEAR;
    cmd.tick_step  = state_r == pfc_pkg::ST_TICK;
    cmd.push       = push;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfc_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;

  // Sweeps always start from entry zero
  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pfc_pkg::ST_IDLE |-> sts.cnt_zero)
    else $error("sweep counter not at zero while idle");

  // One result per item: never two loads in a row
  a_push_once: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !push)
    else $error("result register loaded twice for one transaction");

  // A clear always runs its sweep
  a_clear_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op == pfc_pkg::OP_CLEAR |=> state_r == pfc_pkg::ST_CLEAR)
    else $error("clear accepted without a clearing sweep");

  // No new item taken while a sweep is in flight
  a_no_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfc_pkg::ST_TICK || state_r == pfc_pkg::ST_CLEAR) |-> !cmd.exec)
    else $error("transaction accepted during a sweep");

endmodule

[rtl/palette_fade_controller.sv]
`timescale 1ns / 1ps

// Palette store with fade sequencer. After reset the block clears every entry
// of both palette stores before it takes its first transaction. A write, fade
// request, read or idle clean frame tick returns its result through the push
// state, which loads the output register once it is free; a clear and a frame
// tick that loads the display each walk all 256 palette entries, one per cycle
// through the palette memories. One item is worked on at a time; the next is
// taken while the previous result still waits in the output register.

module palette_fade_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] entry_index, [15:8] red_in, [23:16] green_in, [31:24] blue_in,
  // [39:32] fade_steps
  input  logic [pfc_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [2:0] opcode
  input  logic [pfc_pkg::OP_W-1:0]          in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [1:0] fade_state, [9:2] red_out, [17:10] green_out, [25:18] blue_out,
  // [31:26] zero
  output logic [pfc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [0] display_loaded
  output logic [pfc_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  pfc_pkg::dp_cmd_t cmd;
  pfc_pkg::dp_sts_t sts;

  pfc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pfc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .op_in    (in_tuser),
    .item_in  (in_tdata),
    .sts      (sts),
    .out_user (out_tuser),
    .out_data (out_tdata)
  );

endmodule

[verif/tb_palette_fade_controller.sv]
`timescale 1ns / 1ps

module tb_palette_fade_controller;
  import pfc_pkg::*;

  localparam int  CLK_HALF       = 4;
  localparam int  ITEM_TARGET    = 2000;
  localparam int  STALL_LIMIT    = 8000;
  localparam int  HOLD_CYCLES    = 1500;
  localparam int  HOLD_AFTER     = 150;
  localparam int  DRAIN_CYCLES   = 300;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [COMP_W-1:0] b;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] r;
  } rgb_t;

  typedef struct packed {
    logic              loaded;
    logic [MODE_W-1:0] state;
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } pal_reply_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [OP_W-1:0]        in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  // Shadow copy of both palettes and the fade sequencer, plus replies still owed
  class palette_shadow;
    rgb_t       base_pal[PALETTE_ENTRIES];
    rgb_t       shown_pal[PALETTE_ENTRIES];
    bit         dirty;
    fade_mode_t fmode;
    int         step_inc;
    int         offset;
    pal_reply_t awaited_replies[$];
    int         errors;

    function new();
      foreach (base_pal[e]) begin
        base_pal[e]  = '0;
        shown_pal[e] = '0;
      end
      dirty    = 1'b0;
      fmode    = MODE_IDLE;
      step_inc = 0;
      offset   = 0;
      errors   = 0;
    endfunction

    function logic [COMP_W-1:0] clamp_comp(int v);
      if (v < 0) return '0;
      if (v > COMP_MAX) return COMP_MAX[COMP_W-1:0];
      return v[COMP_W-1:0];
    endfunction

    function int clip_step(logic [COMP_W-1:0] raw);
      return (raw == '0) ? 1 : int'(raw);
    endfunction

    // Advance the shadow by one accepted transaction and queue its reply
    function void apply_item(logic [OP_W-1:0] op, logic [IN_TDATA_W-1:0] data);
      logic [IDX_W-1:0] idx;
      int               used;
      bit               going;
      pal_reply_t       rep;
      idx = data[7:0];
      rep = '0;
      case (op)
        OP_WRITE: begin
          base_pal[idx] = {data[31:24], data[23:16], data[15:8]};
          dirty = 1'b1;
        end
        OP_CLEAR: begin
          foreach (base_pal[e]) base_pal[e] = '0;
          base_pal[1] = RGB_WHITE;
          dirty = 1'b1;
        end
        OP_FADE_IN: begin
          if (fmode == MODE_IDLE) begin
            step_inc = clip_step(data[39:32]);
            offset   = -FADE_START;
            fmode    = MODE_IN;
          end
        end
        OP_FADE_OUT: begin
          if (fmode == MODE_IDLE) begin
            step_inc = -clip_step(data[39:32]);
            offset   = FADE_START;
            fmode    = MODE_OUT;
          end
        end
        OP_TICK: begin
          if (fmode == MODE_IDLE) begin
            if (dirty) begin
              dirty       = 1'b0;
              shown_pal   = base_pal;
              rep.loaded  = 1'b1;
            end
          end else begin
            // the faded copy uses the offset from before the step
            dirty  = 1'b0;
            used   = offset;
            offset = offset + step_inc;
            going  = (fmode == MODE_OUT) ? (offset > 0) : (offset < 0);
            if (going) begin
              foreach (shown_pal[e]) begin
                shown_pal[e].r = clamp_comp(int'(base_pal[e].r) + used);
                shown_pal[e].g = clamp_comp(int'(base_pal[e].g) + used);
                shown_pal[e].b = clamp_comp(int'(base_pal[e].b) + used);
              end
            end else begin
              fmode     = MODE_IDLE;
              shown_pal = base_pal;
            end
            rep.loaded = 1'b1;
          end
        end
        OP_READ: begin
          rep.r = shown_pal[idx].r;
          rep.g = shown_pal[idx].g;
          rep.b = shown_pal[idx].b;
        end
        default: ;
      endcase
      rep.state = fmode;
      awaited_replies.push_back(rep);
    endfunction

    function void compare_field(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
        errors++;
      end
    endfunction

    // Match one accepted result against the oldest reply owed
    function void check_reply(logic [OUT_TDATA_W-1:0] data, logic [OUT_TUSER_W-1:0] user);
      pal_reply_t want;
      if (awaited_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %0h/%0h",
                 $time, data, user);
        errors++;
        return;
      end
      want = awaited_replies.pop_front();
      compare_field("display_loaded", want.loaded, user[0]);
      compare_field("fade_state", want.state, data[1:0]);
      compare_field("red_out", want.r, data[9:2]);
      compare_field("green_out", want.g, data[17:10]);
      compare_field("blue_out", want.b, data[25:18]);
      compare_field("padding", 0, data[31:26]);
    endfunction
  endclass

  palette_shadow shadow;
  int            items_sent;
  int            burst_left;

  palette_fade_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [IN_TDATA_W-1:0] pack_item(int idx, int r, int g, int b, int steps);
    return {steps[7:0], b[7:0], g[7:0], r[7:0], idx[7:0]};
  endfunction

  function automatic int pick_index();
    return ($urandom_range(1, 0) == 1) ? $urandom_range(15, 0) : $urandom_range(255, 0);
  endfunction

  // Mostly coarse steps so fades finish quickly, now and then a slow one
  function automatic int pick_step();
    int sel;
    sel = $urandom_range(99, 0);
    if (sel < 5) return $urandom_range(7, 0);
    if (sel < 25) return $urandom_range(63, 8);
    return $urandom_range(255, 64);
  endfunction

  function automatic logic [IN_TDATA_W-1:0] any_data();
    return {8'($urandom_range(255, 0)), 32'($urandom)};
  endfunction

  // Offer one transaction, wait for acceptance, then keep or break the burst
  task automatic push_item(input logic [OP_W-1:0] op, input logic [IN_TDATA_W-1:0] data);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    shadow.apply_item(op, data);
    if (op <= OP_READ) items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(200, 50) : $urandom_range(8, 0);
    end
  endtask

  task automatic push_write();
    push_item(OP_WRITE, pack_item(pick_index(), $urandom_range(255, 0),
              $urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0)));
  endtask

  task automatic push_read();
    push_item(OP_READ, pack_item(pick_index(), $urandom_range(255, 0),
              $urandom_range(255, 0), $urandom_range(255, 0), $urandom_range(255, 0)));
  endtask

  // Start a fade if idle, then tick it through to the end with traffic mixed in
  task automatic fade_run();
    int sel;
    if (shadow.fmode == MODE_IDLE)
      push_item(($urandom_range(1, 0) == 1) ? OP_FADE_IN : OP_FADE_OUT,
                pack_item(pick_index(), 0, 0, 0, pick_step()));
    while (shadow.fmode != MODE_IDLE) begin
      sel = $urandom_range(99, 0);
      if (sel < 45)      push_item(OP_TICK, any_data());
      else if (sel < 75) push_read();
      else if (sel < 88) push_write();
      else if (sel < 95) push_item(($urandom_range(1, 0) == 1) ? OP_FADE_IN : OP_FADE_OUT,
                                   any_data());
      else if (sel < 98) push_item(OP_CLEAR, any_data());
      else               push_item(($urandom_range(1, 0) == 1) ? OP_SPARE_LO : OP_SPARE_HI,
                                   any_data());
    end
    push_item(OP_TICK, any_data());
    push_read();
  endtask

  task automatic load_run();
    int n;
    n = $urandom_range(8, 1);
    repeat (n) push_write();
    push_item(OP_TICK, any_data());
    repeat (n) push_read();
  endtask

  task automatic noise_run();
    repeat ($urandom_range(20, 5))
      push_item(3'($urandom_range(7, 0)), any_data());
  endtask

  task automatic directed_items();
    push_item(OP_READ,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_WRITE,    pack_item(0, 255, 0, 128, 0));
    push_item(OP_WRITE,    pack_item(255, 0, 255, 127, 255));
    push_item(OP_READ,     pack_item(255, 0, 0, 0, 0));
    push_item(OP_TICK,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_TICK,     pack_item(255, 255, 255, 255, 255));
    push_item(OP_READ,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_READ,     pack_item(255, 0, 0, 0, 0));
    push_item(OP_CLEAR,    pack_item(0, 0, 0, 0, 0));
    push_item(OP_READ,     pack_item(1, 0, 0, 0, 0));
    push_item(OP_TICK,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_READ,     pack_item(1, 0, 0, 0, 0));
    push_item(OP_READ,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_WRITE,    pack_item(2, 128, 64, 1, 0));
    // full step ends the fade on its first tick
    push_item(OP_FADE_OUT, pack_item(0, 0, 0, 0, 255));
    push_item(OP_FADE_IN,  pack_item(0, 0, 0, 0, 10));
    push_item(OP_TICK,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_READ,     pack_item(2, 0, 0, 0, 0));
    push_item(OP_FADE_IN,  pack_item(0, 0, 0, 0, 200));
    push_item(OP_TICK,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_READ,     pack_item(1, 0, 0, 0, 0));
    push_item(OP_TICK,     pack_item(0, 0, 0, 0, 0));
    push_item(OP_READ,     pack_item(1, 0, 0, 0, 0));
    push_item(OP_SPARE_LO, pack_item(255, 255, 255, 255, 255));
    push_item(OP_SPARE_HI, pack_item(0, 0, 0, 0, 0));
    // zero step counts as one and runs on into the random part
    push_item(OP_FADE_IN,  pack_item(0, 0, 0, 0, 0));
  endtask

  // Stimulus and end of run
  initial begin
    int sel;
    shadow     = new();
    items_sent = 0;
    burst_left = 0;
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    while (items_sent < ITEM_TARGET) begin
      sel = $urandom_range(99, 0);
      if (shadow.fmode != MODE_IDLE || sel < 40) fade_run();
      else if (sel < 85)                         load_run();
      else                                       noise_run();
    end
    in_tvalid <= 1'b0;
    while (shadow.awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: changing stall styles and one long hold-off
  initial begin
    int  cyc;
    int  style;
    int  seen;
    int  hold_cnt;
    bit  held;
    out_tready = 1'b0;
    cyc   = 0;
    style = 0;
    seen  = 0;
    held  = 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (rst_n && out_tvalid && out_tready) begin
        shadow.check_reply(out_tdata, out_tuser);
        seen++;
      end
      if (!held && seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
      end else begin
        if (cyc % 50 == 0) style = $urandom_range(3, 0);
        case (style)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(3, 0) != 0);
          2:       out_tready <= (cyc % 3 == 0);
          default: out_tready <= ($urandom_range(9, 0) < 3);
        endcase
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
rtl/pfc_pkg.sv
rtl/pfc_datapath.sv
rtl/pfc_ctrl.sv
rtl/palette_fade_controller.sv
verif/tb_palette_fade_controller.sv
